[rtl/morse_character_keyer_defines.svh]
// assertion macros for the morse character keyer checker
`ifndef MORSE_CHARACTER_KEYER_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_DEFINES_SVH

// same-cycle implication
`define MCK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("morse keyer check failed");

// next-cycle implication
`define MCK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("morse keyer check failed");

`endif

[rtl/mck_pkg.sv]
// shared types, constants and code lookup for the morse character keyer
package mck_pkg;

    localparam int CHAR_W = 8;
    localparam int DIT_W  = 11;
    localparam int DUR_W  = 13;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 3;

    localparam logic [DIT_W-1:0] DIT_RESET = 11'd60;
    localparam logic [DIT_W-1:0] GAP_TRIM  = 11'd7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_DIT = 1'b0;

    // character codes
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_EXCL   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_QUERY  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_PARA   = 8'd182;

    localparam logic [CODE_W-1:0] LETTER_CODES [26] = '{
        8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10, 8'h04, 8'h17,
        8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F, 8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03,
        8'h09, 8'h11, 8'h0B, 8'h19, 8'h1B, 8'h1C
    };

    localparam logic [CODE_W-1:0] DIGIT_CODES [10] = '{
        8'h3F, 8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38, 8'h3C, 8'h3E
    };

    typedef struct packed {
        logic load_char;
        logic emit_pause;
        logic emit_first;
        logic emit_gap;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        logic code_zero;
        logic idx_zero;
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_MARK  = 5'b00100,
        ST_GAP   = 5'b01000,
        ST_PAUSE = 5'b10000
    } state_t;

    // code byte with start marker, zero for no code
    function automatic logic [CODE_W-1:0] code_for(input logic [CHAR_W-1:0] c);
        logic [4:0] letter_idx;
        logic [CODE_W-1:0] code;
        letter_idx = c[4:0] - 5'd1;
        code = '0;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]})
        begin
            code = LETTER_CODES[letter_idx];
        end
        else if (c inside {[CH_ZERO:CH_NINE]})
        begin
            code = DIGIT_CODES[c[3:0]];
        end
        else
        begin
            case (c)
                CH_LF, CH_CR, CH_EXCL: code = 8'h6B;
                CH_QUOTE:  code = 8'h52;
                CH_DOLLAR: code = 8'h89;
                CH_AT:     code = 8'h28;
                CH_APOS:   code = 8'h5E;
                CH_LPAREN: code = 8'h36;
                CH_RPAREN: code = 8'h6D;
                CH_COMMA:  code = 8'h73;
                CH_DOT:    code = 8'h55;
                CH_MINUS:  code = 8'h61;
                CH_COLON:  code = 8'h78;
                CH_SEMI:   code = 8'h6A;
                CH_QUERY:  code = 8'h4C;
                CH_UNDER:  code = 8'h4D;
                CH_PARA:   code = 8'h68;
                default:   code = '0;
            endcase
        end
        return code;
    endfunction

    // position of the start marker
    function automatic logic [IDX_W-1:0] marker_pos(input logic [CODE_W-1:0] code);
        logic [IDX_W-1:0] pos;
        pos = '0;
        for (int b = 1; b < CODE_W; b++)
        begin
            if (code[b])
            begin
                pos = IDX_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

[rtl/mck_ctrl.sv]
// keyer controller: sequences the intervals of one character
module mck_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mck_pkg::status_t status,
    output mck_pkg::cmd_t    cmd
);
    import mck_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_MARK) || (state_reg == ST_GAP) ||
                       (state_reg == ST_PAUSE);
    assign out_xfer  = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_char = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.code_zero)
                begin
                    cmd.emit_pause = 1'b1;
                    state_next     = ST_PAUSE;
                end
                else
                begin
                    cmd.emit_first = 1'b1;
                    state_next     = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (out_xfer)
                begin
                    cmd.emit_gap = 1'b1;
                    state_next   = ST_GAP;
                end
            end
            ST_GAP:
            begin
                if (out_xfer)
                begin
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_MARK;
                    end
                end
            end
            ST_PAUSE:
            begin
                if (out_xfer)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/mck_dp.sv]
// keyer datapath: code lookup, element index and interval output register
module mck_dp (
    input  logic                           clk,
    input  logic [mck_pkg::CHAR_W-1:0]     char_code,
    input  logic [mck_pkg::DIT_W-1:0]      dit_length_ms,
    input  mck_pkg::cmd_t                  cmd,
    output mck_pkg::status_t               status,
    output logic                           key_down,
    output logic [mck_pkg::DUR_W-1:0]      duration_ms,
    output logic                           last
);
    import mck_pkg::*;

    logic [CODE_W-1:0] code_reg;
    logic [DIT_W-1:0]  dit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              key_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic              last_reg;

    logic [DUR_W-1:0]  dit_dur;
    logic [DUR_W-1:0]  dah_dur;
    logic [DUR_W-1:0]  pause_dur;
    logic [DUR_W-1:0]  gap_dur;
    logic [DUR_W-1:0]  mark_dur;

    assign dit_dur   = {2'b00, dit_reg};
    assign dah_dur   = {2'b00, dit_reg} + {1'b0, dit_reg, 1'b0};
    assign pause_dur = {dit_reg, 2'b00};
    assign gap_dur   = (dit_reg > GAP_TRIM) ? {2'b00, dit_reg - GAP_TRIM} : '0;

    // element to send next
    assign idx_next = cmd.emit_first ? (marker_pos(code_reg) - IDX_W'(1))
                                     : (idx_reg - IDX_W'(1));
    assign mark_dur = code_reg[idx_next] ? dah_dur : dit_dur;

    assign status.code_zero = (code_reg == '0);
    assign status.idx_zero  = (idx_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            code_reg <= code_for(char_code);
            dit_reg  <= dit_length_ms;
        end
        if (cmd.emit_pause)
        begin
            key_reg  <= 1'b0;
            dur_reg  <= pause_dur;
            last_reg <= 1'b1;
        end
        if (cmd.emit_first || cmd.emit_next)
        begin
            idx_reg  <= idx_next;
            key_reg  <= 1'b1;
            dur_reg  <= mark_dur;
            last_reg <= 1'b0;
        end
        if (cmd.emit_gap)
        begin
            key_reg  <= 1'b0;
            dur_reg  <= (idx_reg == '0) ? dah_dur : gap_dur;
            last_reg <= (idx_reg == '0);
        end
    end

    assign key_down    = key_reg;
    assign duration_ms = dur_reg;
    assign last        = last_reg;

endmodule

[rtl/morse_character_keyer.sv]
// morse character keyer top level with register port
// One character is taken on the input channel while the block is idle and
// comes out as its Morse intervals, mark then gap for each element, the
// final gap flagged by last; space and characters without a code give one
// four-dit pause. A coded character has at most 7 elements; the
// controller walks one element at a time through the single output
// register, and the next character is taken once the last interval has
// been transferred. The dit length is sampled when a character is taken.
module morse_character_keyer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mck_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mck_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mck_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic [mck_pkg::CHAR_W-1:0]        char_code,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic                              key_down,
    output logic [mck_pkg::DUR_W-1:0]         duration_ms,
    output logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import mck_pkg::*;

    logic [DIT_W-1:0] dit_reg;
    logic             reg_idx;
    cmd_t             cmd;
    status_t          status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg <= DIT_RESET;
        end
        else if (psel && penable && pwrite && (reg_idx == REG_IDX_DIT))
        begin
            dit_reg <= pwdata[DIT_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_IDX_DIT) ?
                    {{(APB_DATA_W-DIT_W){1'b0}}, dit_reg} : '0;

    mck_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mck_dp u_dp (
        .clk           (clk),
        .char_code     (char_code),
        .dit_length_ms (dit_reg),
        .cmd           (cmd),
        .status        (status),
        .key_down      (key_down),
        .duration_ms   (duration_ms),
        .last          (last)
    );

endmodule

[rtl/mck_checker.sv]
// port-level checks for the morse character keyer and their bind
`include "morse_character_keyer_defines.svh"

module mck_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic key_down,
    input logic last,
    input logic out_valid,
    input logic out_ready
);

    // no new character while an interval is on offer
    `MCK_ASSERT_NOW(a_busy_excl, out_valid, !in_ready)
    // a character occupies the block after its transfer
    `MCK_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready)
    // the final interval frees the input
    `MCK_ASSERT_NEXT(a_last_idle, out_valid && out_ready && last, in_ready)
    // an interval that is not final is followed at once by another
    `MCK_ASSERT_NEXT(a_more, out_valid && out_ready && !last, out_valid)
    // a character never ends on a keyed interval
    `MCK_ASSERT_NOW(a_mark_not_last, out_valid && key_down, !last)

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key_down  (key_down),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
